FILE: rtl/smeu_pkg.sv
`default_nettype none
package smeu_pkg;
    localparam int unsigned STACK_DEPTH_DEF    = 64;
    localparam int unsigned REGISTER_COUNT_DEF = 8;
    localparam int unsigned DATA_W             = 32;
    localparam int unsigned CMD_W              = 4;
    localparam int unsigned STATUS_W           = 3;

    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SQRT  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_OUT   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_IN    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_PUSHR = 4'd8;
    localparam logic [CMD_W-1:0] CMD_POPR  = 4'd9;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STACK   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADREG  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SQRTNEG = 3'd4;

    typedef struct packed {
        logic               start;
        logic               is_sqrt;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
    } alu_req_t;
endpackage
`default_nettype wire

FILE: rtl/smeu_ram.sv
`default_nettype none
module smeu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/smeu_alu.sv
`default_nettype none
module smeu_alu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire smeu_pkg::alu_req_t req,
    output logic                   done,
    output logic [31:0]            result
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        sqrt_reg, sqrt_next;
    logic        neg_reg, neg_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] q_reg, q_next;
    logic [33:0] rs;
    logic [33:0] trial;
    logic [33:0] sdiff;
    logic [32:0] ddiff;
    logic [31:0] ma, mb;

    assign ma = req.a[31] ? 32'(-req.a) : req.a;
    assign mb = req.b[31] ? 32'(-req.b) : req.b;
    assign rs = {r_reg[31:0], x_reg[31:30]};
    assign trial = {q_reg, 2'b01};
    assign sdiff = rs - trial;
    assign ddiff = {r_reg[31:0], x_reg[31]} - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sqrt_next = sqrt_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        done      = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            sqrt_next = req.is_sqrt;
            cnt_next  = req.is_sqrt ? 6'd16 : 6'd32;
            x_next    = req.is_sqrt ? req.a : ma;
            d_next    = mb;
            neg_next  = req.a[31] ^ req.b[31];
            r_next    = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
            else if (sqrt_reg)
            begin
                cnt_next = cnt_reg - 6'd1;
                x_next   = {x_reg[29:0], 2'b00};
                if (!sdiff[33])
                begin
                    r_next = sdiff[32:0];
                    q_next = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = rs[32:0];
                    q_next = {q_reg[30:0], 1'b0};
                end
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
                x_next   = {x_reg[30:0], 1'b0};
                if (!ddiff[32])
                begin
                    r_next = {1'b0, ddiff[31:0]};
                    q_next = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = {r_reg[31:0], x_reg[31]};
                    q_next = {q_reg[30:0], 1'b0};
                end
            end
        end
    end

    assign result = (!sqrt_reg && neg_reg) ? 32'(-q_reg) : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
        neg_reg  <= neg_next;
        x_reg    <= x_next;
        d_reg    <= d_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
    end
endmodule
`default_nettype wire

FILE: rtl/stack_machine_execute_unit.sv
`default_nettype none
// Stack machine execute unit.
// Input: drive cmd and operand with start high; the instruction transfers at
// the rising edge where start is high and busy is low. busy stays high until
// the result has been shown.
// Output: done is high for exactly one cycle with status, out_valid and
// out_value; the receiver takes the transfer at the end of that cycle and
// cannot stall it.
// States before DONE: push, in, pushr run EXEC, PUSH; out, popr run RD1, RD2,
// EXEC; add, sub run RD1, RD2, EXEC, PUSH; mul, div, sqrt add MUL or ALU before PUSH.
// The stack lives in one synchronous RAM with one read port; each pop is a
// RAM read, so binary operations read twice, and the shared shift-subtract
// unit retires one quotient bit, or one root bit per radicand bit pair, per cycle.
// Throughput: one instruction at a time; the next may transfer the cycle
// after done.
// Reset: the stack is empty and all registers read as zero. Stack entries
// are not cleared; only entries below the count are ever read.
module stack_machine_execute_unit #(
    parameter int unsigned STACK_DEPTH    = smeu_pkg::STACK_DEPTH_DEF,
    parameter int unsigned REGISTER_COUNT = smeu_pkg::REGISTER_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [smeu_pkg::CMD_W-1:0]     cmd,
    input  wire logic signed [31:0]             operand,
    output logic                                done,
    output logic [smeu_pkg::STATUS_W-1:0]       status,
    output logic                                out_valid,
    output logic signed [31:0]                  out_value
);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned RW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RD1   = 8'b00000010,
        S_RD2   = 8'b00000100,
        S_EXEC  = 8'b00001000,
        S_MUL   = 8'b00010000,
        S_ALU   = 8'b00100000,
        S_PUSH  = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [3:0]  cmd_reg;
    logic [31:0] opnd_reg;
    logic [31:0] a_reg, a_next, b_reg, b_next;
    logic [31:0] pv_reg, pv_next;
    logic [2:0]  st_reg, st_next;
    logic        ov_reg, ov_next;
    logic [31:0] oval_reg, oval_next;
    logic [REGISTER_COUNT-1:0] rv_reg;
    logic [31:0] rf_reg [REGISTER_COUNT];
    logic        rf_we;
    logic [RW-1:0] ridx;
    logic        reg_ok;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] rdata;
    smeu_pkg::alu_req_t areq;
    logic        adone;
    logic [31:0] ares;
    logic [31:0] rfval;

    smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(we), .waddr(waddr), .wdata(pv_reg),
        .raddr(raddr), .rdata(rdata)
    );

    smeu_alu u_alu (.clk(clk), .rst_n(rst_n), .req(areq), .done(adone), .result(ares));

    assign ridx   = opnd_reg[RW-1:0];
    assign reg_ok = !opnd_reg[31] && (opnd_reg < 32'(REGISTER_COUNT));
    assign rfval  = rv_reg[ridx] ? rf_reg[ridx] : 32'd0;
    assign raddr  = AW'(cnt_reg - CW'(1));
    assign waddr  = AW'(cnt_reg);
    assign we     = (state_reg == S_PUSH) && (cnt_reg < CW'(STACK_DEPTH));
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        pv_next    = pv_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        oval_next  = oval_reg;
        rf_we      = 1'b0;
        areq       = '{start: 1'b0, is_sqrt: 1'b0, a: a_reg, b: b_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    st_next    = smeu_pkg::ST_OK;
                    ov_next    = 1'b0;
                    oval_next  = '0;
                    state_next = S_EXEC;
                    case (cmd)
                        smeu_pkg::CMD_ADD, smeu_pkg::CMD_SUB, smeu_pkg::CMD_MUL,
                        smeu_pkg::CMD_DIV, smeu_pkg::CMD_SQRT, smeu_pkg::CMD_OUT,
                        smeu_pkg::CMD_POPR: state_next = S_RD1;
                        default: state_next = S_EXEC;
                    endcase
                end
            end
            S_RD1:
            begin
                if (cmd_reg == smeu_pkg::CMD_POPR && !reg_ok)
                begin
                    st_next    = smeu_pkg::ST_BADREG;
                    state_next = S_DONE;
                end
                else if (cnt_reg == '0)
                begin
                    st_next    = smeu_pkg::ST_STACK;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                a_next = rdata;
                state_next = S_EXEC;
                case (cmd_reg)
                    smeu_pkg::CMD_ADD, smeu_pkg::CMD_SUB, smeu_pkg::CMD_MUL:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next    = smeu_pkg::ST_STACK;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - CW'(1);
                        end
                    end
                    smeu_pkg::CMD_DIV:
                    begin
                        if (rdata == '0)
                        begin
                            pv_next    = rdata;
                            st_next    = smeu_pkg::ST_DIVZERO;
                            state_next = S_PUSH;
                        end
                        else if (cnt_reg == '0)
                        begin
                            st_next    = smeu_pkg::ST_STACK;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - CW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    smeu_pkg::CMD_ADD:
                    begin
                        pv_next = a_reg + rdata;
                        state_next = S_PUSH;
                    end
                    smeu_pkg::CMD_SUB:
                    begin
                        pv_next = rdata - a_reg;
                        state_next = S_PUSH;
                    end
                    smeu_pkg::CMD_MUL:
                    begin
                        b_next = rdata;
                        state_next = S_MUL;
                    end
                    smeu_pkg::CMD_DIV:
                    begin
                        areq = '{start: 1'b1, is_sqrt: 1'b0, a: rdata, b: a_reg};
                        state_next = S_ALU;
                    end
                    smeu_pkg::CMD_SQRT:
                    begin
                        pv_next = a_reg;
                        if (a_reg[31])
                        begin
                            st_next = smeu_pkg::ST_SQRTNEG;
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            areq = '{start: 1'b1, is_sqrt: 1'b1, a: a_reg, b: a_reg};
                            state_next = S_ALU;
                        end
                    end
                    smeu_pkg::CMD_PUSH, smeu_pkg::CMD_IN:
                    begin
                        pv_next = opnd_reg;
                        state_next = S_PUSH;
                    end
                    smeu_pkg::CMD_OUT:
                    begin
                        ov_next = 1'b1;
                        oval_next = a_reg;
                    end
                    smeu_pkg::CMD_PUSHR:
                    begin
                        if (!reg_ok)
                        begin
                            st_next = smeu_pkg::ST_BADREG;
                        end
                        else
                        begin
                            pv_next = rfval;
                            state_next = S_PUSH;
                        end
                    end
                    smeu_pkg::CMD_POPR:
                    begin
                        rf_we = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_MUL:
            begin
                pv_next = a_reg * b_reg;
                state_next = S_PUSH;
            end
            S_ALU:
            begin
                if (adone)
                begin
                    pv_next = ares;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (cnt_reg < CW'(STACK_DEPTH))
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    st_next = smeu_pkg::ST_STACK;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign done      = (state_reg == S_DONE);
    assign status    = st_reg;
    assign out_valid = ov_reg;
    assign out_value = oval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rv_reg    <= '0;
            st_reg    <= '0;
            ov_reg    <= 1'b0;
            oval_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            st_reg    <= st_next;
            ov_reg    <= ov_next;
            oval_reg  <= oval_next;
            if (rf_we)
            begin
                rv_reg[ridx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg  <= cmd;
            opnd_reg <= operand;
        end
        if (rf_we)
        begin
            rf_reg[ridx] <= a_reg;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        pv_reg   <= pv_next;
    end
endmodule
`default_nettype wire

FILE: rtl/smeu_checker.sv
`default_nettype none
module smeu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [2:0]  status,
    input wire logic        out_valid,
    input wire logic [31:0] out_value
);
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("transfer did not raise busy");
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result held more than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_valid) |-> (status == smeu_pkg::ST_OK))
        else $error("out with error status");
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !out_valid) |-> (out_value == 32'd0))
        else $error("stray out value");
endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .out_valid(out_valid), .out_value(out_value)
);
`default_nettype wire
